// ----- rtl/core/bgr_to_nv12_420_converter_core_macros.svh -----
// Assertion macros shared by the converter RTL.
// Every macro samples on the rising edge of clock.
`ifndef BGR_TO_NV12_420_CONVERTER_CORE_MACROS_SVH
`define BGR_TO_NV12_420_CONVERTER_CORE_MACROS_SVH

// Check a property outside of reset.
`define B2NV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define B2NV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/core/b2nv_pkg.sv -----
package b2nv_pkg;

   // Pixel and configuration widths
   localparam int PIX_W    = 8;
   localparam int SUM_W    = PIX_W + 1;
   localparam int SIZE_W   = 13;
   localparam int COUNT_W  = 12;
   localparam int CSR_IDX_W = 2;

   // Canvas limits and line store geometry
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int LINE_W     = 3 * SUM_W;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(640);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // One accepted pixel as it leaves the raster stage
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [SUM_W-1:0] sum_blue;
      logic [SUM_W-1:0] sum_green;
      logic [SUM_W-1:0] sum_red;
      logic             chroma;
      logic             frame_end;
   } beat_type;

   // Line store access for the current beat
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [LINE_AW-1:0] addr;
      logic [LINE_W-1:0]  wr_data;
   } line_ctl_type;

endpackage

// ----- rtl/core/bgr_to_nv12_420_converter_core.sv -----
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_blue, req_green, req_red
// rsp       out        rsp_valid/rsp_ready   rsp_luma, rsp_chroma_valid, rsp_chroma_blue,
//                                            rsp_chroma_red, rsp_frame_end
// csr       in         csr_write_enable      csr_index, csr_write_data
//
// One pixel per clock while rsp is not stalled; each result passes stage 1, stage 2 (luma and
// block means) and the output register (chroma), with the line store read in flight in stage 1.
// Synchronous reset clears counters, left pixel and valid bits; sizes go to 640.
// A stalled result freezes the whole pipe; req_ready drops only while rsp is full
// and not taken.
`include "bgr_to_nv12_420_converter_core_macros.svh"

module bgr_to_nv12_420_converter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [b2nv_pkg::PIX_W-1:0]     req_blue,
   input  logic [b2nv_pkg::PIX_W-1:0]     req_green,
   input  logic [b2nv_pkg::PIX_W-1:0]     req_red,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [b2nv_pkg::PIX_W-1:0]     rsp_luma,
   output logic                           rsp_chroma_valid,
   output logic [b2nv_pkg::PIX_W-1:0]     rsp_chroma_blue,
   output logic [b2nv_pkg::PIX_W-1:0]     rsp_chroma_red,
   output logic                           rsp_frame_end,
   input  logic                           csr_write_enable,
   input  logic [b2nv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [b2nv_pkg::SIZE_W-1:0]    csr_write_data
);
   import b2nv_pkg::*;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic              advance;
   logic              accept;
   beat_type          beat;
   line_ctl_type      line;
   logic [LINE_W-1:0] line_rd_data;

   // Size registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_write_data;
            CSR_FRAME_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req_ready = advance;
   assign accept    = req_valid & advance;

   // Raster position, left pixel and line store control
   b2nv_raster u_raster (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .blue         (req_blue),
      .green        (req_green),
      .red          (req_red),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .beat         (beat),
      .line         (line)
   );

   // Pair sums of the even row
   b2nv_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line.wr_en),
      .wr_addr (line.addr),
      .wr_data (line.wr_data),
      .rd_en   (line.rd_en),
      .rd_addr (line.addr),
      .rd_data (line_rd_data)
   );

   // Luma and chroma arithmetic with the output register
   b2nv_pixel_pipe u_pipe (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .beat             (beat),
      .line_rd_data     (line_rd_data),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_chroma_blue  (rsp_chroma_blue),
      .rsp_chroma_red   (rsp_chroma_red),
      .rsp_frame_end    (rsp_frame_end)
   );

   `B2NV_ASSERT_ALWAYS(a_line_one_port, !(line.wr_en && line.rd_en), "line store read and write together")
   `B2NV_ASSERT(a_chroma_zero, (rsp_valid && !rsp_chroma_valid) |-> (rsp_chroma_blue == '0 && rsp_chroma_red == '0), "chroma bytes set without a block")
   `B2NV_ASSERT(a_ready_only_on_stall, !req_ready |-> (rsp_valid && !rsp_ready), "input stalled while output free")

endmodule

// ----- rtl/core/b2nv_ram.sv -----
module b2nv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port that holds without a read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/b2nv_raster.sv -----
module b2nv_raster (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [b2nv_pkg::PIX_W-1:0]  blue,
   input  logic [b2nv_pkg::PIX_W-1:0]  green,
   input  logic [b2nv_pkg::PIX_W-1:0]  red,
   input  logic [b2nv_pkg::SIZE_W-1:0] frame_width,
   input  logic [b2nv_pkg::SIZE_W-1:0] frame_height,
   output b2nv_pkg::beat_type          beat,
   output b2nv_pkg::line_ctl_type      line
);
   import b2nv_pkg::*;

   logic [COUNT_W-1:0]   col_ff, col_in;
   logic [COUNT_W-1:0]   row_ff, row_in;
   logic [3*PIX_W-1:0]   hold_ff, hold_in;
   logic [SIZE_W-1:0]    width_eff, height_eff;
   logic                 last_col, last_row;
   logic [SUM_W-1:0]     sum_b, sum_g, sum_r;

   // Even size, zero taken as two, capped at the limit
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                  input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] s;
      s = {raw[SIZE_W-1:1], 1'b0};
      if (s == '0) s = SIZE_W'(2);
      if (s > limit) s = limit;
      return s;
   endfunction

   assign width_eff  = eff_size(frame_width, SIZE_W'(MAX_WIDTH));
   assign height_eff = eff_size(frame_height, SIZE_W'(MAX_HEIGHT));
   assign last_col   = ({1'b0, col_ff} + SIZE_W'(1)) >= width_eff;
   assign last_row   = ({1'b0, row_ff} + SIZE_W'(1)) >= height_eff;

   // Horizontal pair sums with the held left pixel
   assign sum_b = SUM_W'(blue)  + SUM_W'(hold_ff[3*PIX_W-1:2*PIX_W]);
   assign sum_g = SUM_W'(green) + SUM_W'(hold_ff[2*PIX_W-1:PIX_W]);
   assign sum_r = SUM_W'(red)   + SUM_W'(hold_ff[PIX_W-1:0]);

   // Advance the raster position on each beat and hold the left pixel on even columns
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      hold_in = hold_ff;
      if (accept) begin
         if (!col_ff[0]) begin
            hold_in = {blue, green, red};
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + COUNT_W'(1);
         end else begin
            col_in = col_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         hold_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         hold_ff <= hold_in;
      end
   end

   // Beat description for the color pipeline
   always_comb begin
      beat.blue      = blue;
      beat.green     = green;
      beat.red       = red;
      beat.sum_blue  = sum_b;
      beat.sum_green = sum_g;
      beat.sum_red   = sum_r;
      beat.chroma    = col_ff[0] & row_ff[0];
      beat.frame_end = last_col & last_row;
   end

   // Even rows store pair sums, odd rows read them back
   always_comb begin
      line.wr_en   = accept & col_ff[0] & ~row_ff[0];
      line.rd_en   = accept & col_ff[0] & row_ff[0];
      line.addr    = col_ff[LINE_AW:1];
      line.wr_data = {sum_b, sum_g, sum_r};
   end

endmodule

// ----- rtl/core/b2nv_pixel_pipe.sv -----
module b2nv_pixel_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  b2nv_pkg::beat_type          beat,
   input  logic [b2nv_pkg::LINE_W-1:0] line_rd_data,
   output logic                        advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [b2nv_pkg::PIX_W-1:0]  rsp_luma,
   output logic                        rsp_chroma_valid,
   output logic [b2nv_pkg::PIX_W-1:0]  rsp_chroma_blue,
   output logic [b2nv_pkg::PIX_W-1:0]  rsp_chroma_red,
   output logic                        rsp_frame_end
);
   import b2nv_pkg::*;

   localparam int LUMA_W = 2 * PIX_W - 1;
   localparam int CHR_W  = 2 * PIX_W + 1;
   localparam int MEAN_W = SUM_W + 1;

   // Stage 1: accepted beat, line store read in flight
   beat_type          s1_beat_ff;
   logic              s1_valid_ff;
   // Stage 2: luma and block means
   logic [PIX_W-1:0]  s2_luma_ff, s2_luma_in;
   logic [PIX_W-1:0]  s2_mb_ff, s2_mb_in;
   logic [PIX_W-1:0]  s2_mg_ff, s2_mg_in;
   logic [PIX_W-1:0]  s2_mr_ff, s2_mr_in;
   logic              s2_chroma_ff, s2_fe_ff, s2_valid_ff;
   // Output register
   logic [PIX_W-1:0]  out_luma_ff, out_u_ff, out_u_in, out_v_ff, out_v_in;
   logic              out_chroma_ff, out_fe_ff, out_valid_ff;

   logic [LUMA_W-1:0] luma_sum;
   logic [MEAN_W-1:0] blk_b, blk_g, blk_r;
   logic [CHR_W-1:0]  u_sum, v_sum;

   // Move the whole pipe whenever the output slot is free or taken
   assign advance = ~out_valid_ff | rsp_ready;

   // Luma: weighted sum, round, shift by seven
   assign luma_sum = LUMA_W'(s1_beat_ff.red) * LUMA_W'(38)
                   + LUMA_W'(s1_beat_ff.green) * LUMA_W'(75)
                   + LUMA_W'(s1_beat_ff.blue) * LUMA_W'(15)
                   + LUMA_W'(64);
   assign s2_luma_in = luma_sum[LUMA_W-1:PIX_W-1];

   // 2x2 block totals, truncated mean
   assign blk_b = MEAN_W'(s1_beat_ff.sum_blue)
                + MEAN_W'(line_rd_data[3*SUM_W-1:2*SUM_W]);
   assign blk_g = MEAN_W'(s1_beat_ff.sum_green)
                + MEAN_W'(line_rd_data[2*SUM_W-1:SUM_W]);
   assign blk_r = MEAN_W'(s1_beat_ff.sum_red)
                + MEAN_W'(line_rd_data[SUM_W-1:0]);
   assign s2_mb_in = blk_b[MEAN_W-1:2];
   assign s2_mg_in = blk_g[MEAN_W-1:2];
   assign s2_mr_in = blk_r[MEAN_W-1:2];

   // Chroma with rounding and the 128 offset folded in; both sums stay positive
   assign u_sum = CHR_W'(32896) + CHR_W'(s2_mb_ff) * CHR_W'(127)
                - CHR_W'(s2_mr_ff) * CHR_W'(43) - CHR_W'(s2_mg_ff) * CHR_W'(84);
   assign v_sum = CHR_W'(32896) + CHR_W'(s2_mr_ff) * CHR_W'(127)
                - CHR_W'(s2_mg_ff) * CHR_W'(107) - CHR_W'(s2_mb_ff) * CHR_W'(20);

   // Clamp to a byte, zero when no block completes
   always_comb begin
      out_u_in = '0;
      out_v_in = '0;
      if (s2_chroma_ff) begin
         out_u_in = u_sum[CHR_W-1] ? '1 : u_sum[CHR_W-2:PIX_W];
         out_v_in = v_sum[CHR_W-1] ? '1 : v_sum[CHR_W-2:PIX_W];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_beat_ff    <= beat;
         s2_luma_ff    <= s2_luma_in;
         s2_mb_ff      <= s2_mb_in;
         s2_mg_ff      <= s2_mg_in;
         s2_mr_ff      <= s2_mr_in;
         s2_chroma_ff  <= s1_beat_ff.chroma;
         s2_fe_ff      <= s1_beat_ff.frame_end;
         out_luma_ff   <= s2_luma_ff;
         out_u_ff      <= out_u_in;
         out_v_ff      <= out_v_in;
         out_chroma_ff <= s2_chroma_ff;
         out_fe_ff     <= s2_fe_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = out_luma_ff;
   assign rsp_chroma_valid = out_chroma_ff;
   assign rsp_chroma_blue  = out_u_ff;
   assign rsp_chroma_red   = out_v_ff;
   assign rsp_frame_end    = out_fe_ff;

endmodule
